// ----- sv/lbss_pkg.sv -----
// Package for the LED bounce and strobe sequencer: register map, defaults and shared types.
package lbss_pkg;

	localparam int LED_COUNT_DEF    = 12;
	localparam int WINDOW_WIDTH_DEF = 3;

	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int PERIOD_W = 10;
	localparam int REPEAT_W = 4;
	localparam int REG_IDX_W = 3;

	// Register indexes, taken from paddr[4:2].
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_SPEED0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_SPEED1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_SPEED2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_SPEED3 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SWEEP_REPEATS = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FLASH_REPEATS = 3'd5;

	localparam logic [PERIOD_W-1:0] PERIOD_SPEED0_RST = 10'd10;
	localparam logic [PERIOD_W-1:0] PERIOD_SPEED1_RST = 10'd50;
	localparam logic [PERIOD_W-1:0] PERIOD_SPEED2_RST = 10'd100;
	localparam logic [PERIOD_W-1:0] PERIOD_SPEED3_RST = 10'd250;
	localparam logic [REPEAT_W-1:0] SWEEP_REPEATS_RST = 4'd4;
	localparam logic [REPEAT_W-1:0] FLASH_REPEATS_RST = 4'd3;

	localparam logic [1:0] SPEED_MIN = 2'd0;
	localparam logic [1:0] SPEED_MAX = 2'd3;

	typedef struct packed {
		logic [3:0][PERIOD_W-1:0] period;
		logic [REPEAT_W-1:0]      sweep_repeats;
		logic [REPEAT_W-1:0]      flash_repeats;
	} cfg_t;

endpackage

// ----- sv/led_bounce_strobe_sequencer.sv -----
// Top level of the LED bounce and strobe sequencer: handshakes, pipeline and result register.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  input    | in        | in_valid/in_stall  | tick, down_edge, up_edge
//  result   | out       | out_valid/out_stall| led_mask[LED_COUNT-1:0]
//  config   | in        | APB psel/penable   | paddr, pwdata, prdata
//
// Each request yields exactly one result, passing first through the input register
// and then through the result register. A new request can be taken every cycle while
// the result side does not stall; the sequencer state is updated in a single pass
// between the input register and the result register.
// The asynchronous reset clears the pipeline valids and puts the sequencer at
// the first sweep position, speed index 0, with the default register values.
// A stall on the result side holds the result register; the input register
// keeps accepting while it is empty or the result register is free or being emptied.
module led_bounce_strobe_sequencer #(
	parameter int LED_COUNT    = lbss_pkg::LED_COUNT_DEF,
	parameter int WINDOW_WIDTH = lbss_pkg::WINDOW_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lbss_pkg::ADDR_W-1:0]   paddr,
	input  logic [lbss_pkg::DATA_W-1:0]   pwdata,
	output logic [lbss_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// Request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          tick,
	input  logic                          down_edge,
	input  logic                          up_edge,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [LED_COUNT-1:0]          led_mask
);

	lbss_pkg::cfg_t       cfg;

	// Input register holding the accepted request.
	logic                 valid_s1;
	logic                 tick_s1;
	logic                 down_s1;
	logic                 up_s1;

	// Result register.
	logic                 out_valid_q;
	logic [LED_COUNT-1:0] led_q;
	logic [LED_COUNT-1:0] led_next;

	logic                 in_accept;
	logic                 s1_go;

	// The request in the input register moves on whenever the result
	// register is empty or is being read in this cycle.
	assign s1_go     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !s1_go;
	assign in_accept = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign led_mask  = led_q;

	lbss_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The sequencer state advances exactly once per request, as it leaves
	// the input register, and hands back the pattern after that update.
	lbss_engine #(
		.LED_COUNT    (LED_COUNT),
		.WINDOW_WIDTH (WINDOW_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_go),
		.tick      (tick_s1),
		.down_edge (down_s1),
		.up_edge   (up_s1),
		.cfg       (cfg),
		.led_next  (led_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			tick_s1 <= tick;
			down_s1 <= down_edge;
			up_s1   <= up_edge;
		end
		if (s1_go) begin
			led_q <= led_next;
		end
	end

endmodule

// ----- sv/lbss_cfg_regs.sv -----
// APB register file holding the step periods and the repeat counts.
module lbss_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lbss_pkg::ADDR_W-1:0]   paddr,
	input  logic [lbss_pkg::DATA_W-1:0]   pwdata,
	output logic [lbss_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output lbss_pkg::cfg_t                cfg
);

	lbss_pkg::cfg_t                      cfg_q;
	logic [lbss_pkg::REG_IDX_W-1:0]      idx;
	logic                                wr_en;

	assign idx    = paddr[lbss_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period[0]     <= lbss_pkg::PERIOD_SPEED0_RST;
			cfg_q.period[1]     <= lbss_pkg::PERIOD_SPEED1_RST;
			cfg_q.period[2]     <= lbss_pkg::PERIOD_SPEED2_RST;
			cfg_q.period[3]     <= lbss_pkg::PERIOD_SPEED3_RST;
			cfg_q.sweep_repeats <= lbss_pkg::SWEEP_REPEATS_RST;
			cfg_q.flash_repeats <= lbss_pkg::FLASH_REPEATS_RST;
		end else if (wr_en) begin
			case (idx)
				lbss_pkg::REG_PERIOD_SPEED0: cfg_q.period[0] <= pwdata[lbss_pkg::PERIOD_W-1:0];
				lbss_pkg::REG_PERIOD_SPEED1: cfg_q.period[1] <= pwdata[lbss_pkg::PERIOD_W-1:0];
				lbss_pkg::REG_PERIOD_SPEED2: cfg_q.period[2] <= pwdata[lbss_pkg::PERIOD_W-1:0];
				lbss_pkg::REG_PERIOD_SPEED3: cfg_q.period[3] <= pwdata[lbss_pkg::PERIOD_W-1:0];
				lbss_pkg::REG_SWEEP_REPEATS: cfg_q.sweep_repeats <= pwdata[lbss_pkg::REPEAT_W-1:0];
				lbss_pkg::REG_FLASH_REPEATS: cfg_q.flash_repeats <= pwdata[lbss_pkg::REPEAT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			lbss_pkg::REG_PERIOD_SPEED0: prdata = lbss_pkg::DATA_W'(cfg_q.period[0]);
			lbss_pkg::REG_PERIOD_SPEED1: prdata = lbss_pkg::DATA_W'(cfg_q.period[1]);
			lbss_pkg::REG_PERIOD_SPEED2: prdata = lbss_pkg::DATA_W'(cfg_q.period[2]);
			lbss_pkg::REG_PERIOD_SPEED3: prdata = lbss_pkg::DATA_W'(cfg_q.period[3]);
			lbss_pkg::REG_SWEEP_REPEATS: prdata = lbss_pkg::DATA_W'(cfg_q.sweep_repeats);
			lbss_pkg::REG_FLASH_REPEATS: prdata = lbss_pkg::DATA_W'(cfg_q.flash_repeats);
			default:                     prdata = '0;
		endcase
	end

endmodule

// ----- sv/lbss_engine.sv -----
// Sequencer state: tick timing, sweep and flash groups, speed index and the next LED pattern.
module lbss_engine #(
	parameter int LED_COUNT    = lbss_pkg::LED_COUNT_DEF,
	parameter int WINDOW_WIDTH = lbss_pkg::WINDOW_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 tick,
	input  logic                 down_edge,
	input  logic                 up_edge,
	input  lbss_pkg::cfg_t       cfg,
	output logic [LED_COUNT-1:0] led_next
);

	localparam int MAX_SHIFT = (LED_COUNT > WINDOW_WIDTH) ? LED_COUNT - WINDOW_WIDTH : 1;
	localparam int LAST_STEP = 2 * MAX_SHIFT;
	localparam int STEP_W    = $clog2(LAST_STEP + 1);
	localparam int PW        = lbss_pkg::PERIOD_W;
	localparam int RW        = lbss_pkg::REPEAT_W;

	localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(1);
	localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(LAST_STEP);
	localparam logic [STEP_W-1:0] STEP_TURN  = STEP_W'(MAX_SHIFT);

	logic [1:0]        speed_q, speed_d;
	logic              pend_down_q, pend_down_d;
	logic              pend_up_q, pend_up_d;
	logic              flash_q, flash_d;
	logic [RW-1:0]     grp_q, grp_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              half_q, half_d;
	logic [PW-1:0]     cnt_q, cnt_d;

	logic              pdn, pup, boundary;
	logic [PW-1:0]     period, dur;
	logic [PW:0]       cnt_inc;
	logic [RW-1:0]     grp_inc;
	logic [STEP_W-1:0] pos;

	always_comb begin
		pdn      = pend_down_q | down_edge;
		pup      = pend_up_q | up_edge;
		speed_d  = speed_q;
		pend_down_d = pdn;
		pend_up_d   = pup;
		flash_d  = flash_q;
		grp_d    = grp_q;
		step_d   = step_q;
		half_d   = half_q;
		cnt_d    = cnt_q;
		boundary = 1'b0;
		period   = cfg.period[speed_q];
		dur      = flash_q ? {1'b0, period[PW-1:1]} : period;
		if (dur == '0) begin
			dur = PW'(1);
		end
		cnt_inc  = {1'b0, cnt_q} + (PW+1)'(1);
		grp_inc  = grp_q + RW'(1);

		if (tick) begin
			if (cnt_inc < {1'b0, dur}) begin
				cnt_d = cnt_inc[PW-1:0];
			end else begin
				cnt_d = '0;
				if (!flash_q) begin
					if (step_q >= STEP_LAST) begin
						step_d   = STEP_FIRST;
						boundary = 1'b1;
						if (grp_inc >= cfg.sweep_repeats) begin
							flash_d = 1'b1;
							grp_d   = '0;
							half_d  = 1'b0;
						end else begin
							grp_d = grp_inc;
						end
					end else begin
						step_d = step_q + STEP_W'(1);
					end
				end else if (!half_q) begin
					half_d = 1'b1;
				end else begin
					half_d = 1'b0;
					if (grp_inc >= cfg.flash_repeats) begin
						flash_d  = 1'b0;
						grp_d    = '0;
						step_d   = STEP_FIRST;
						boundary = 1'b1;
					end else begin
						grp_d = grp_inc;
					end
				end
			end
		end

		// Slow-down is applied before speed-up, both saturating.
		if (boundary) begin
			if (pdn && speed_d != lbss_pkg::SPEED_MIN) begin
				speed_d = speed_d - 2'd1;
			end
			if (pup && speed_d != lbss_pkg::SPEED_MAX) begin
				speed_d = speed_d + 2'd1;
			end
			pend_down_d = 1'b0;
			pend_up_d   = 1'b0;
		end

		// Window position bounces: rising up to the turn, then falling back.
		pos = (step_d <= STEP_TURN) ? step_d : STEP_LAST - step_d;
		for (int k = 0; k < LED_COUNT; k++) begin
			if (flash_d) begin
				led_next[k] = half_d;
			end else begin
				led_next[k] = (k >= int'(pos)) && (k < int'(pos) + WINDOW_WIDTH);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q     <= lbss_pkg::SPEED_MIN;
			pend_down_q <= 1'b0;
			pend_up_q   <= 1'b0;
			flash_q     <= 1'b0;
			grp_q       <= '0;
			step_q      <= STEP_FIRST;
			half_q      <= 1'b0;
			cnt_q       <= '0;
		end else if (step) begin
			speed_q     <= speed_d;
			pend_down_q <= pend_down_d;
			pend_up_q   <= pend_up_d;
			flash_q     <= flash_d;
			grp_q       <= grp_d;
			step_q      <= step_d;
			half_q      <= half_d;
			cnt_q       <= cnt_d;
		end
	end

endmodule

// ----- tb/lbss_led_checker.sv -----
// Checker for the LED sequencer bench: tracks register writes, predicts led_mask and compares.
module lbss_led_checker #(
	parameter int LED_COUNT    = lbss_pkg::LED_COUNT_DEF,
	parameter int WINDOW_WIDTH = lbss_pkg::WINDOW_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [lbss_pkg::ADDR_W-1:0] paddr,
	input  logic [lbss_pkg::DATA_W-1:0] pwdata,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        tick,
	input  logic                        down_edge,
	input  logic                        up_edge,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [LED_COUNT-1:0]        led_mask,
	input  logic                        run_over,
	output int                          mismatches,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import lbss_pkg::*;

	localparam int MAX_SHIFT = (LED_COUNT > WINDOW_WIDTH) ? LED_COUNT - WINDOW_WIDTH : 1;
	localparam int LAST_STEP = 2 * MAX_SHIFT;
	localparam logic [LED_COUNT-1:0] WINDOW_ONES = LED_COUNT'((1 << WINDOW_WIDTH) - 1);

	// Register copy
	logic [PERIOD_W-1:0] period_r [4];
	logic [REPEAT_W-1:0] sweeps_r;
	logic [REPEAT_W-1:0] flashes_r;

	// Sequencer copy
	logic [1:0]          speed;
	logic                want_down;
	logic                want_up;
	logic                flashing;
	logic [REPEAT_W-1:0] grp_cnt;
	logic [4:0]          win_step;
	logic                lit_half;
	logic [PERIOD_W-1:0] tick_cnt;

	logic [LED_COUNT-1:0] led_expect_q [$];
	int                   result_idx;
	bit                   leftover_seen;

	initial mismatches = 0;

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatches++;
	endtask

	// Latched button edges move the speed index only at a group boundary.
	task automatic apply_buttons();
		if (want_down && speed != SPEED_MIN)
			speed = speed - 1'b1;
		if (want_up && speed != SPEED_MAX)
			speed = speed + 1'b1;
		want_down = 1'b0;
		want_up   = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin : sample
		int                   dur;
		int                   pos;
		logic [LED_COUNT-1:0] leds;
		logic [LED_COUNT-1:0] wanted;
		if (!arst_n) begin
			period_r[0] = PERIOD_SPEED0_RST;
			period_r[1] = PERIOD_SPEED1_RST;
			period_r[2] = PERIOD_SPEED2_RST;
			period_r[3] = PERIOD_SPEED3_RST;
			sweeps_r    = SWEEP_REPEATS_RST;
			flashes_r   = FLASH_REPEATS_RST;
			speed       = SPEED_MIN;
			want_down   = 1'b0;
			want_up     = 1'b0;
			flashing    = 1'b0;
			grp_cnt     = '0;
			win_step    = 5'd1;
			lit_half    = 1'b0;
			tick_cnt    = '0;
			led_expect_q.delete();
			result_idx  = 0;
			leftover_seen = 1'b0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_PERIOD_SPEED0: period_r[0] = pwdata[PERIOD_W-1:0];
					REG_PERIOD_SPEED1: period_r[1] = pwdata[PERIOD_W-1:0];
					REG_PERIOD_SPEED2: period_r[2] = pwdata[PERIOD_W-1:0];
					REG_PERIOD_SPEED3: period_r[3] = pwdata[PERIOD_W-1:0];
					REG_SWEEP_REPEATS: sweeps_r    = pwdata[REPEAT_W-1:0];
					REG_FLASH_REPEATS: flashes_r   = pwdata[REPEAT_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				if (down_edge)
					want_down = 1'b1;
				if (up_edge)
					want_up = 1'b1;
				if (tick) begin
					dur = int'(period_r[speed]);
					if (flashing)
						dur = dur / 2;
					if (dur == 0)
						dur = 1;
					if (int'(tick_cnt) + 1 < dur) begin
						tick_cnt = tick_cnt + 1'b1;
					end else begin
						tick_cnt = '0;
						if (!flashing) begin
							if (int'(win_step) >= LAST_STEP) begin
								win_step = 5'd1;
								grp_cnt  = grp_cnt + 1'b1;
								if (grp_cnt >= sweeps_r) begin
									flashing = 1'b1;
									grp_cnt  = '0;
									lit_half = 1'b0;
								end
								apply_buttons();
							end else begin
								win_step = win_step + 1'b1;
							end
						end else if (!lit_half) begin
							lit_half = 1'b1;
						end else begin
							lit_half = 1'b0;
							grp_cnt  = grp_cnt + 1'b1;
							if (grp_cnt >= flashes_r) begin
								flashing = 1'b0;
								grp_cnt  = '0;
								win_step = 5'd1;
								apply_buttons();
							end
						end
					end
				end
				if (flashing) begin
					leds = lit_half ? '1 : '0;
				end else begin
					pos  = (int'(win_step) <= MAX_SHIFT) ? int'(win_step)
						: LAST_STEP - int'(win_step);
					leds = WINDOW_ONES << pos;
				end
				led_expect_q.push_back(leds);
			end

			if (out_valid && !out_stall) begin
				if (led_expect_q.size() == 0) begin
					report_mismatch($sformatf("result %0d led_mask %03h arrived with nothing expected",
						result_idx, led_mask));
				end else begin
					wanted = led_expect_q.pop_front();
					if (led_mask !== wanted)
						report_mismatch($sformatf("result %0d led_mask %03h, expected %03h",
							result_idx, led_mask, wanted));
				end
				result_idx++;
			end

			if (run_over && !leftover_seen && led_expect_q.size() != 0) begin
				report_mismatch($sformatf("%0d expected results never arrived",
					led_expect_q.size()));
				leftover_seen = 1'b1;
			end
			outstanding <= led_expect_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Top of the LED sequencer bench: clock, reset, stimulus, register programming and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lbss_pkg::*;

	// Register indexes beyond the map; writes there must leave everything untouched.
	localparam logic [REG_IDX_W-1:0] REG_UNUSED6 = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED7 = 3'd7;

	localparam int LED_COUNT       = LED_COUNT_DEF;
	localparam int PHASES          = 8;
	localparam int REQS_PER_PHASE  = 166;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_CYCLES     = 60;
	localparam int WATCHDOG_LIMIT  = 2000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [ADDR_W-1:0]    paddr     = '0;
	logic [DATA_W-1:0]    pwdata    = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic                 tick      = 1'b0;
	logic                 down_edge = 1'b0;
	logic                 up_edge   = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [LED_COUNT-1:0] led_mask;
	logic                 run_over  = 1'b0;

	int mismatches;
	int outstanding;

	// Idling mix of the current phase, in percent.
	int src_idle_pct    = 0;
	int stall_pct       = 0;
	// Each increment asks the result side for one long hold-off.
	int hold_off_ticket = 0;

	int req_count = 0;
	int res_count = 0;

	wire in_acc = in_valid && !in_stall;
	wire out_acc = out_valid && !out_stall;
	wire cfg_wr = psel && penable && pwrite && pready;

	always #5 clk = ~clk;

	led_bounce_strobe_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.tick      (tick),
		.down_edge (down_edge),
		.up_edge   (up_edge),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.led_mask  (led_mask)
	);

	lbss_led_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.tick        (tick),
		.down_edge   (down_edge),
		.up_edge     (up_edge),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.led_mask    (led_mask),
		.run_over    (run_over),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Result side. A hold-off keeps the stall up for a fixed stretch, counted here, so that
	// the sequencer fills its two registers and has to stall the request side. Otherwise the
	// stall is drawn afresh every cycle from the phase's percentage.
	always @(posedge clk) begin : result_side
		int hold_served;
		int hold_left;
		if (hold_off_ticket != hold_served) begin
			hold_served = hold_off_ticket;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_acc)
				req_count++;
			if (out_acc)
				res_count++;
		end
	end

	// The watchdog gives up once nothing has moved on any port for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (in_acc || out_acc || cfg_wr)
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] watchdog: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// Offers one request after a random run of idle cycles and returns at the edge that
	// takes it. The payload is held steady for as long as the request is stalled.
	task automatic send_req(input logic t, input logic d, input logic u);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		tick      <= t;
		down_edge <= d;
		up_edge   <= u;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stops offering requests until every expected result has come back, then lets the
	// pipeline settle so that the sequencer is quiet before any register is touched.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all six registers in turn, optionally followed by writes to the two unmapped
	// indexes. Each write is a setup phase followed by an access phase.
	task automatic program_registers(input logic [31:0] p0, input logic [31:0] p1,
		input logic [31:0] p2, input logic [31:0] p3, input logic [31:0] sw,
		input logic [31:0] fl, input bit stray);
		logic [REG_IDX_W-1:0] idx [8];
		logic [31:0]          val [8];
		int                   count;
		idx[0] = REG_PERIOD_SPEED0; val[0] = p0;
		idx[1] = REG_PERIOD_SPEED1; val[1] = p1;
		idx[2] = REG_PERIOD_SPEED2; val[2] = p2;
		idx[3] = REG_PERIOD_SPEED3; val[3] = p3;
		idx[4] = REG_SWEEP_REPEATS; val[4] = sw;
		idx[5] = REG_FLASH_REPEATS; val[5] = fl;
		idx[6] = REG_UNUSED6;       val[6] = $urandom();
		idx[7] = REG_UNUSED7;       val[7] = $urandom();
		count = stray ? 8 : 6;
		for (int k = 0; k < count; k++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {idx[k], 2'b00};
			pwdata  <= val[k];
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin : stimulus
		logic [31:0] per [4];
		logic [31:0] sw;
		logic [31:0] fl;
		bit          stray;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at the default registers: an item with no tick, edges latched
		// with and without a tick, and both buttons at once while the index sits at its
		// lower limit.
		send_req(1'b0, 1'b0, 1'b0);
		send_req(1'b0, 1'b1, 1'b0);
		send_req(1'b1, 1'b0, 1'b1);
		send_req(1'b1, 1'b1, 1'b1);
		wait_drained();

		// Zero and one periods both count as a single tick, and zero repeats act as one, so
		// a whole sweep ends after eighteen ticks. The last of them carries a down edge,
		// which must join that very boundary; the flash that follows is one tick per half.
		program_registers(32'd0, 32'd1, 32'd2, 32'd1023, 32'd0, 32'd0, 1'b0);
		for (int k = 1; k <= 20; k++)
			send_req(1'b1, k == 18, k == 20);
		wait_drained();

		// Phases with fixed or random settings. Each one reprograms every register, and in turn
		// they use the idling mixes: none, sender idle, receiver stalling, and both at once.
		for (int ph = 0; ph < PHASES; ph++) begin
			stray = 1'b0;
			case (ph)
				0: begin
					per = '{32'd2, 32'd3, 32'd4, 32'd5};
					sw  = 32'd1;
					fl  = 32'd1;
				end
				1: begin
					per = '{32'd1, 32'd0, 32'd2, 32'd3};
					sw  = 32'd15;
					fl  = 32'd15;
				end
				3: begin
					// A very long step at the slowest index keeps the tick counter climbing.
					per = '{32'd1023, 32'd2, 32'd3, 32'd4};
					sw  = 32'd2;
					fl  = 32'd2;
				end
				4: begin
					// Junk above the register widths must be dropped by the write.
					foreach (per[i])
						per[i] = ($urandom() & 32'hFFFF_FC00) | $urandom_range(0, 7);
					sw    = ($urandom() & 32'hFFFF_FFF0) | $urandom_range(0, 4);
					fl    = ($urandom() & 32'hFFFF_FFF0) | $urandom_range(0, 4);
					stray = 1'b1;
				end
				5: begin
					per = '{32'd2, 32'd2, 32'd2, 32'd2};
					sw  = 32'd0;
					fl  = 32'd15;
				end
				7: begin
					per = '{32'd2, 32'd3, 32'd4, 32'd1023};
					sw  = 32'd1;
					fl  = 32'd1;
				end
				default: begin
					foreach (per[i])
						per[i] = $urandom_range(0, 6);
					sw = $urandom_range(0, 3);
					fl = $urandom_range(0, 3);
				end
			endcase
			program_registers(per[0], per[1], per[2], per[3], sw, fl, stray);

			case (ph % 4)
				0: begin
					src_idle_pct = 0;
					stall_pct   <= 0;
				end
				1: begin
					src_idle_pct = 59;
					stall_pct   <= 0;
				end
				2: begin
					src_idle_pct = 0;
					stall_pct   <= 59;
				end
				default: begin
					src_idle_pct = 18;
					stall_pct   <= 18;
				end
			endcase

			for (int n = 0; n < REQS_PER_PHASE; n++) begin
				// In the first phase the result side holds off for a long stretch while
				// requests keep coming, so the input side has to stall.
				if (ph == 0 && n == 30)
					hold_off_ticket <= hold_off_ticket + 1;
				send_req($urandom_range(99) < 85, $urandom_range(99) < 10,
					$urandom_range(99) < 12);
			end
			wait_drained();
		end

		stall_pct <= 0;
		wait_drained();
		run_over <= 1'b1;
		repeat (2) @(posedge clk);

		$display("Summary: %0d requests and %0d results over %0d register settings,",
			req_count, res_count, PHASES + 2);
		$display("with zero, one and maximum periods and repeats, all idling mixes and a long hold-off.");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/lbss_pkg.sv
sv/lbss_cfg_regs.sv
sv/lbss_engine.sv
sv/led_bounce_strobe_sequencer.sv
tb/lbss_led_checker.sv
tb/tb_top.sv
